### rtl/ks_pkg.sv
// ----------------------------------------------------------------------------
// ks_pkg
// Shared widths and the command and status bundles between the knapsack
// controller and its datapath.
// ----------------------------------------------------------------------------
package ks_pkg;

  localparam int CAP_W = 10;
  localparam int VAL_W = 16;
  localparam int ROW_W = 21;
  localparam int IDX_W = 5;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  typedef struct packed {
    logic clear;
    logic clr_init;
    logic load;
    logic sweep;
    logic tb_init;
    logic tb_rd;
    logic tb_ev;
    logic em_init;
    logic em_next;
    logic em_load;
    logic em_none;
  } ks_cmd_t;

  typedef struct packed {
    logic can_load;
    logic cap_zero;
    logic tcap_zero;
    logic sweep_last;
    logic clr_done;
    logic tb_end;
    logic none_picked;
    logic cur_pick;
    logic last_pick;
    logic out_free;
  } ks_stat_t;

endpackage

### rtl/ks_ctrl.sv
// ----------------------------------------------------------------------------
// ks_ctrl
// Sequencer for clearing, row sweeps, traceback and result emission.
// ----------------------------------------------------------------------------
module ks_ctrl
  import ks_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  input  logic     s_last_i,
  output logic     s_ready_o,
  input  ks_stat_t stat_i,
  output ks_cmd_t  cmd_o
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SWEEP   = 4'd2;
  localparam logic [3:0] S_DRAIN   = 4'd3;
  localparam logic [3:0] S_TB_INIT = 4'd4;
  localparam logic [3:0] S_TB_RD   = 4'd5;
  localparam logic [3:0] S_TB_EV   = 4'd6;
  localparam logic [3:0] S_EM_INIT = 4'd7;
  localparam logic [3:0] S_EM_NONE = 4'd8;
  localparam logic [3:0] S_EM_RD   = 4'd9;
  localparam logic [3:0] S_EM_WR   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       last_q, last_d;

  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          last_d     = s_last_i;
          if (stat_i.can_load && !stat_i.cap_zero) state_d = S_SWEEP;
          else if (s_last_i) state_d = S_TB_INIT;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = last_q ? S_TB_INIT : S_IDLE;
      end
      S_TB_INIT: begin
        cmd_o.tb_init = 1'b1;
        state_d = stat_i.tcap_zero ? S_EM_INIT : S_TB_RD;
      end
      S_TB_RD: begin
        cmd_o.tb_rd = 1'b1;
        state_d = S_TB_EV;
      end
      S_TB_EV: begin
        cmd_o.tb_ev = 1'b1;
        state_d = stat_i.tb_end ? S_EM_INIT : S_TB_RD;
      end
      S_EM_INIT: begin
        cmd_o.em_init = 1'b1;
        state_d = stat_i.none_picked ? S_EM_NONE : S_EM_RD;
      end
      S_EM_NONE: begin
        if (stat_i.out_free) begin
          cmd_o.em_none  = 1'b1;
          cmd_o.clr_init = 1'b1;
          state_d = S_CLEAR;
        end
      end
      S_EM_RD: begin
        state_d = S_EM_WR;
      end
      S_EM_WR: begin
        if (!stat_i.cur_pick) begin
          cmd_o.em_next = 1'b1;
          state_d = S_EM_RD;
        end else if (stat_i.out_free) begin
          cmd_o.em_load = 1'b1;
          if (stat_i.last_pick) begin
            cmd_o.clr_init = 1'b1;
            state_d = S_CLEAR;
          end else begin
            cmd_o.em_next = 1'b1;
            state_d = S_EM_RD;
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

endmodule

### rtl/ks_dp.sv
// ----------------------------------------------------------------------------
// ks_dp
// Datapath: best-value row, take marks, item store, traceback and output
// register.
// ----------------------------------------------------------------------------
module ks_dp
  import ks_pkg::*;
#(
  parameter int MAX_ITEMS    = 32,
  parameter int MAX_CAPACITY = 1023
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ks_cmd_t          cmd_i,
  output ks_stat_t         stat_o,
  input  logic [CAP_W-1:0] cap_i,
  input  logic [CAP_W-1:0] item_w_i,
  input  logic [VAL_W-1:0] item_v_i,
  input  logic             m_ready_i,
  output logic             m_valid_o,
  output logic [ROW_W-1:0] max_value_o,
  output logic [IDX_W-1:0] chosen_index_o,
  output logic [CAP_W-1:0] chosen_weight_o,
  output logic [VAL_W-1:0] chosen_value_o,
  output logic             none_selected_o,
  output logic             items_dropped_o,
  output logic             last_result_o
);

  localparam int DEPTH = MAX_CAPACITY + 1;
  localparam int RAW   = (MAX_CAPACITY < 2) ? 1 : $clog2(MAX_CAPACITY + 1);
  localparam int IAW   = (MAX_ITEMS < 2) ? 1 : $clog2(MAX_ITEMS);
  localparam int CNW   = $clog2(MAX_ITEMS + 1);

  logic [ROW_W-1:0]     best_mem [DEPTH];
  logic [MAX_ITEMS-1:0] mark_mem [DEPTH];
  logic [CAP_W-1:0]     stw_mem  [MAX_ITEMS];
  logic [VAL_W-1:0]     stv_mem  [MAX_ITEMS];

  logic [RAW-1:0]       cap_eff;
  logic [RAW-1:0]       j_q, tcap_q, clr_q, tj_q, p_j_q;
  logic [CAP_W-1:0]     w_q;
  logic [VAL_W-1:0]     v_q;
  logic [IAW-1:0]       idx_q, ti_q, eidx_q;
  logic [CNW-1:0]       cnt_q;
  logic                 drop_q, p_vld_q, p_ok_q;
  logic [ROW_W-1:0]     best_a_q, best_b_q, maxv_q;
  logic [MAX_ITEMS-1:0] mark_rd_q, picked_q;
  logic [CAP_W-1:0]     sw_q;
  logic [VAL_W-1:0]     sv_q;

  logic [RAW-1:0]       best_a_addr, best_b_addr, mark_addr;
  logic [IAW-1:0]       st_addr;
  logic [ROW_W:0]       cand;
  logic [ROW_W-1:0]     sat;
  logic                 chg, tb_bit;
  logic [RAW-1:0]       tj_next;

  always_comb begin
    if (32'(cap_i) > 32'(MAX_CAPACITY)) cap_eff = RAW'(MAX_CAPACITY);
    else cap_eff = RAW'(cap_i);
  end

  assign best_a_addr = cmd_i.sweep ? j_q : tcap_q;
  assign best_b_addr = (32'(w_q) <= 32'(j_q)) ? RAW'(32'(j_q) - 32'(w_q)) : '0;
  assign mark_addr   = cmd_i.sweep ? j_q : tj_q;
  assign st_addr     = cmd_i.tb_rd ? ti_q : eidx_q;

  assign cand = {1'b0, best_b_q} + (ROW_W + 1)'(v_q);
  assign sat  = cand[ROW_W] ? '1 : cand[ROW_W-1:0];
  assign chg  = p_ok_q && (sat > best_a_q);

  assign tb_bit  = mark_rd_q[ti_q];
  assign tj_next = (32'(sw_q) <= 32'(tj_q)) ? RAW'(32'(tj_q) - 32'(sw_q)) : '0;

  always_comb begin
    stat_o             = '0;
    stat_o.can_load    = 32'(cnt_q) < 32'(MAX_ITEMS);
    stat_o.cap_zero    = cap_eff == '0;
    stat_o.tcap_zero   = tcap_q == '0;
    stat_o.sweep_last  = j_q == RAW'(1);
    stat_o.clr_done    = clr_q == RAW'(MAX_CAPACITY);
    stat_o.tb_end      = (ti_q == '0) || (tb_bit && (tj_next == '0));
    stat_o.none_picked = picked_q == '0;
    stat_o.cur_pick    = picked_q[eidx_q];
    stat_o.last_pick   = ((picked_q >> eidx_q) >> 1) == '0;
    stat_o.out_free    = !m_valid_o || m_ready_i;
  end

  always_ff @(posedge clk_i) begin
    best_a_q  <= best_mem[best_a_addr];
    best_b_q  <= best_mem[best_b_addr];
    mark_rd_q <= mark_mem[mark_addr];
    if (cmd_i.clear) begin
      best_mem[clr_q] <= '0;
      mark_mem[clr_q] <= '0;
    end else if (p_vld_q) begin
      if (chg) best_mem[p_j_q] <= sat;
      mark_mem[p_j_q] <= mark_rd_q | (chg ? (MAX_ITEMS'(1) << idx_q) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    sw_q <= stw_mem[st_addr];
    sv_q <= stv_mem[st_addr];
    if (cmd_i.load && stat_o.can_load) begin
      stw_mem[cnt_q[IAW-1:0]] <= item_w_i;
      stv_mem[cnt_q[IAW-1:0]] <= item_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_j_q  <= j_q;
    p_ok_q <= 32'(w_q) <= 32'(j_q);
    if (cmd_i.load) begin
      tcap_q <= cap_eff;
      j_q    <= cap_eff;
      w_q    <= item_w_i;
      v_q    <= item_v_i;
      idx_q  <= cnt_q[IAW-1:0];
    end else if (cmd_i.sweep) begin
      j_q <= j_q - RAW'(1);
    end
    if (cmd_i.tb_init) begin
      tj_q   <= tcap_q;
      ti_q   <= IAW'(cnt_q - CNW'(1));
      maxv_q <= '0;
    end
    if (cmd_i.tb_rd) maxv_q <= best_a_q;
    if (cmd_i.tb_ev) begin
      if (tb_bit) tj_q <= tj_next;
      ti_q <= ti_q - IAW'(1);
    end
    if (cmd_i.em_init) eidx_q <= '0;
    else if (cmd_i.em_next) eidx_q <= eidx_q + IAW'(1);
    if (cmd_i.em_load) begin
      max_value_o     <= maxv_q;
      chosen_index_o  <= IDX_W'(eidx_q);
      chosen_weight_o <= sw_q;
      chosen_value_o  <= sv_q;
      none_selected_o <= 1'b0;
      items_dropped_o <= drop_q;
      last_result_o   <= stat_o.last_pick;
    end else if (cmd_i.em_none) begin
      max_value_o     <= maxv_q;
      chosen_index_o  <= '0;
      chosen_weight_o <= '0;
      chosen_value_o  <= '0;
      none_selected_o <= 1'b1;
      items_dropped_o <= drop_q;
      last_result_o   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      clr_q     <= '0;
      p_vld_q   <= 1'b0;
      picked_q  <= '0;
      m_valid_o <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.sweep;
      if (cmd_i.clr_init) begin
        clr_q  <= '0;
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end else begin
        if (cmd_i.clear) clr_q <= clr_q + RAW'(1);
        if (cmd_i.load) begin
          if (stat_o.can_load) cnt_q <= cnt_q + CNW'(1);
          else drop_q <= 1'b1;
        end
      end
      if (cmd_i.tb_init) picked_q <= '0;
      else if (cmd_i.tb_ev && tb_bit) picked_q[ti_q] <= 1'b1;
      if (cmd_i.em_load || cmd_i.em_none) m_valid_o <= 1'b1;
      else if (m_ready_i) m_valid_o <= 1'b0;
    end
  end

endmodule

### rtl/knapsack_01_select.sv
// ----------------------------------------------------------------------------
// knapsack_01_select
// 0-1 knapsack solver: items stream in, the best-value row is swept once per
// item, and a traceback emits the chosen items after the last one.
//
// channel   direction  handshake                 payload
// s_axis    in         tvalid/tready             tdata: weight, value; tlast
// m_axis    out        tvalid/tready             tdata: result; tuser; tlast
// apb       in         psel/penable/pwrite       capacity at address 0
//
// An item is accepted, then swept one row entry per cycle through the
// two-read row memory, each entry written back after it is read; with zero
// capacity or a dropped item, it is only accepted. Traceback reads and
// evaluates each item examined; emission reads each load index up to the
// highest chosen one. After reset and after each answer, every one of the
// MAX_CAPACITY + 1 row entries is cleared before the next item is accepted.
// A stalled result holds the output register and the emission sequence.
// ----------------------------------------------------------------------------
module knapsack_01_select
  import ks_pkg::*;
#(
  parameter int MAX_ITEMS    = 32,
  parameter int MAX_CAPACITY = 1023
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // item_weight, item_value
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // max_value, chosen_index, chosen_weight, chosen_value
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // none_selected, items_dropped
  output logic                   m_axis_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic [2:0] ADDR_CAPACITY = 3'd0;

  logic [CAP_W-1:0] cap_q;
  ks_cmd_t          cmd;
  ks_stat_t         stat;
  logic [ROW_W-1:0] max_value;
  logic [IDX_W-1:0] chosen_index;
  logic [CAP_W-1:0] chosen_weight;
  logic [VAL_W-1:0] chosen_value;
  logic             none_selected, items_dropped;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? 32'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  ks_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ks_dp #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cap_i           (cap_q),
    .item_w_i        (s_axis_tdata[CAP_W-1:0]),
    .item_v_i        (s_axis_tdata[CAP_W+VAL_W-1:CAP_W]),
    .m_ready_i       (m_axis_tready),
    .m_valid_o       (m_axis_tvalid),
    .max_value_o     (max_value),
    .chosen_index_o  (chosen_index),
    .chosen_weight_o (chosen_weight),
    .chosen_value_o  (chosen_value),
    .none_selected_o (none_selected),
    .items_dropped_o (items_dropped),
    .last_result_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, chosen_value, chosen_weight, chosen_index, max_value};
  assign m_axis_tuser = {items_dropped, none_selected};

  a_last_item_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input accepted right after a last item");

  a_none_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[51:21] == '0 && m_axis_tlast)
    else $error("empty answer carries item fields");

  a_pick_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> 21'(m_axis_tdata[51:36]) <= m_axis_tdata[20:0])
    else $error("chosen value exceeds best total");

endmodule

### test/knapsack_01_select_tb.sv
// ----------------------------------------------------------------------------
// knapsack_01_select_tb
// Streams knapsack problems into the solver under random sender bursts and
// receiver stalls, predicts every answer from an internal model of the
// best-value row and take marks, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module knapsack_01_select_tb
  import ks_pkg::*;
;

  localparam int MaxItems = 32;
  localparam int MaxCap   = 1023;
  localparam int IdleLimit = 200000;
  localparam logic [2:0] AddrCapacity = 3'd0;

  typedef struct packed {
    logic [ROW_W-1:0] max_value;
    logic [IDX_W-1:0] index;
    logic [CAP_W-1:0] weight;
    logic [VAL_W-1:0] value;
    logic             none;
    logic             dropped;
    logic             last;
  } answer_t;

  class knapsack_board;
    logic [ROW_W-1:0] row [MaxCap+1];
    logic [63:0]      marks [MaxCap+1];
    logic [CAP_W-1:0] weights [MaxItems];
    logic [VAL_W-1:0] values [MaxItems];
    int               count;
    bit               dropped;
    int               capacity;
    answer_t          pending [$];
    int               errors;

    function void clear_problem();
      for (int j = 0; j <= MaxCap; j++) begin
        row[j] = '0;
        marks[j] = '0;
      end
      count = 0;
      dropped = 0;
    endfunction

    function void note_item(logic [CAP_W-1:0] w, logic [VAL_W-1:0] v, bit last);
      int j;
      int picks [$];
      logic [ROW_W-1:0] best;
      longint cand;
      answer_t a;
      if (count < MaxItems) begin
        weights[count] = w;
        values[count] = v;
        for (j = capacity; j >= 1; j--) begin
          if (w <= j) begin
            cand = longint'(v) + row[j-w];
            if (cand > 2097151) cand = 2097151;
            if (cand > row[j]) begin
              row[j] = cand[ROW_W-1:0];
              marks[j][count] = 1'b1;
            end
          end
        end
        count++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      j = capacity;
      best = row[j];
      for (int i = count - 1; i >= 0 && j > 0; i--) begin
        if (marks[j][i]) begin
          picks.push_front(i);
          j = (weights[i] <= j) ? j - weights[i] : 0;
        end
      end
      if (picks.size() == 0) begin
        a = '0;
        a.max_value = best;
        a.none = 1;
        a.dropped = dropped;
        a.last = 1;
        pending.insert(pending.size(), a);
      end
      foreach (picks[k]) begin
        a.max_value = best;
        a.index = IDX_W'(picks[k]);
        a.weight = weights[picks[k]];
        a.value = values[picks[k]];
        a.none = 0;
        a.dropped = dropped;
        a.last = (k == picks.size() - 1);
        pending.insert(pending.size(), a);
      end
      clear_problem();
    endfunction

    function void check_answer(answer_t got);
      answer_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.max_value != e.max_value) begin
        $error("max_value exp %0d got %0d", e.max_value, got.max_value); errors++;
      end
      if (got.index != e.index) begin
        $error("chosen_index exp %0d got %0d", e.index, got.index); errors++;
      end
      if (got.weight != e.weight) begin
        $error("chosen_weight exp %0d got %0d", e.weight, got.weight); errors++;
      end
      if (got.value != e.value) begin
        $error("chosen_value exp %0d got %0d", e.value, got.value); errors++;
      end
      if (got.none != e.none) begin
        $error("none_selected exp %0d got %0d", e.none, got.none); errors++;
      end
      if (got.dropped != e.dropped) begin
        $error("items_dropped exp %0d got %0d", e.dropped, got.dropped); errors++;
      end
      if (got.last != e.last) begin
        $error("last_result exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  knapsack_board board;
  int hold_off = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  knapsack_01_select i_dut (.*);

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      answer_t got;
      got.max_value = m_axis_tdata[ROW_W-1:0];
      got.index = m_axis_tdata[ROW_W +: IDX_W];
      got.weight = m_axis_tdata[ROW_W+IDX_W +: CAP_W];
      got.value = m_axis_tdata[ROW_W+IDX_W+CAP_W +: VAL_W];
      got.none = m_axis_tuser[0];
      got.dropped = m_axis_tuser[1];
      got.last = m_axis_tlast;
      board.check_answer(got);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_capacity(int c);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= AddrCapacity; pwdata <= c;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.capacity = c;
  endtask

  task automatic send_item(int w, int v, bit last);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'b0, v[VAL_W-1:0], w[CAP_W-1:0]};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(w[CAP_W-1:0], v[VAL_W-1:0], last);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic random_problem(int cap, int n, bit heavy);
    int w;
    for (int i = 0; i < n; i++) begin
      w = heavy ? $urandom_range(0, 1023) : $urandom_range(0, cap + 2);
      send_item(w, $urandom_range(0, 65535), i == n - 1);
    end
  endtask

  initial begin
    board = new();
    board.clear_problem();
    board.capacity = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    // zero capacity: nothing fits
    send_item(1, 65535, 0);
    send_item(0, 5, 1);
    drain();
    write_capacity(20);
    send_item(0, 65535, 0);
    send_item(1023, 65535, 0);
    send_item(20, 100, 0);
    send_item(10, 60, 0);
    send_item(10, 50, 1);
    send_item(21, 7, 1);
    drain();
    write_capacity(1023);
    send_item(1023, 65535, 0);
    send_item(512, 0, 0);
    send_item(511, 43690, 1);
    drain();
    // overflow of item store, with a long receiver hold-off
    write_capacity(8);
    hold_off = 3000;
    for (int i = 0; i < 36; i++) send_item(1, 1000 + i, i == 35);
    for (int i = 0; i < 4; i++) send_item($urandom_range(0, 9), $urandom_range(0, 65535), i == 3);
    drain();
    write_capacity(32);
    hold_off = 300;
    random_problem(32, 40, 0);
    drain();
    for (int p = 0; p < 14; p++) begin
      int c;
      c = (p % 5 == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
      write_capacity(c);
      random_problem(c, $urandom_range(1, 10), p % 7 == 3);
      drain();
    end
    write_capacity(1023);
    random_problem(1023, 3, 1);
    drain();
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ks_pkg.sv
rtl/ks_ctrl.sv
rtl/ks_dp.sv
rtl/knapsack_01_select.sv
test/knapsack_01_select_tb.sv
